// ===== rtl/ps2mt_pkg.sv =====
// Shared constants, codes and types of the PS/2 mouse packet tracker.
`default_nettype none
package ps2mt_pkg;

	localparam int SUM_WIDTH  = 16;   // per-poll move totals, signed
	localparam int DATA_W     = 8;
	localparam int MOVE_W     = 8;
	localparam int BTN_W      = 3;
	localparam int POS_W      = 15;
	localparam int SIZE_W     = 14;
	localparam int PROD_W     = POS_W + SIZE_W;
	localparam int STEP_SHIFT = 9;    // 512 position units per move unit
	localparam int M_TDATA_W  = 80;   // 77 payload bits, padded to bytes
	localparam int CFG_IDX_W  = 1;

	localparam logic [POS_W-1:0] POS_MAX    = POS_W'(32767);
	localparam logic [POS_W-1:0] POS_CENTER = POS_W'(16384);

	// header byte bits
	localparam int SYNC_BIT  = 3;
	localparam int XSIGN_BIT = 4;
	localparam int YSIGN_BIT = 5;

	// input kinds carried on tuser
	localparam logic MODE_BYTE     = 1'b0;
	localparam logic MODE_POLL_END = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_PX  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_PX = CFG_IDX_W'(1);

	typedef struct packed {
		logic signed [MOVE_W-1:0] move_x;
		logic signed [MOVE_W-1:0] move_y;
		logic [BTN_W-1:0]         buttons;
		logic [POS_W-1:0]         pos_x;
		logic [POS_W-1:0]         pos_y;
		logic                     scaled;
	} report_t;

endpackage
`default_nettype wire

// ===== rtl/ps2_mouse_packet_tracker.sv =====
// Top level of the PS/2 mouse packet tracker.
//
// Takes a stream of received PS/2 mouse bytes and end-of-poll markers (tuser
// high), assembles three-byte packets (header, X, Y), accumulates saturating
// per-poll move totals and, at each end of poll that follows at least one
// packet, emits one report beat: the totals clamped to -128..127, the buttons
// of the last packet, a 15-bit absolute position that moves 512 units per
// count (Y inverted, clamped to 0..32767) and that position scaled to the
// screen size. Data bytes and idle polls emit nothing; a header byte must
// have bit 3 set or it is dropped. One input beat is taken every cycle; a
// stalled output only holds the input once the report pipeline behind it is
// full. After its end-of-poll beat is accepted, a report lands in the input
// register, then advances through the position update register, the product
// register (the two 15x14 multipliers) and the divide-by-32767 correction
// into the output register.
// Write screen sizes only while the block is idle; a zero size turns scaling
// off and zeroes both pixel fields.
`default_nettype none
module ps2_mouse_packet_tracker (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// input stream
	input  wire                                   s_tvalid,
	output logic                                  s_tready,
	input  wire  [ps2mt_pkg::DATA_W-1:0]          s_tdata,  // [7:0] data_byte
	input  wire                                   s_tuser,  // [0] mode
	// report stream
	output logic                                  m_tvalid,
	input  wire                                   m_tready,
	// [7:0] move_x, [15:8] move_y, [18:16] button_bits, [33:19] position_x,
	// [48:34] position_y, [62:49] pixel_x, [76:63] pixel_y, [79:77] zero
	output logic [ps2mt_pkg::M_TDATA_W-1:0]       m_tdata,
	output logic                                  m_tuser,  // [0] scaled_valid
	// configuration writes
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire  [ps2mt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [ps2mt_pkg::SIZE_W-1:0]          cfg_data
);

	localparam int PAYLOAD_W = 2*ps2mt_pkg::MOVE_W + ps2mt_pkg::BTN_W
		+ 2*ps2mt_pkg::POS_W + 2*ps2mt_pkg::SIZE_W;

	logic [ps2mt_pkg::SIZE_W-1:0] width_q, height_q;
	logic                         v_s1, mode_s1;
	logic [ps2mt_pkg::DATA_W-1:0] byte_s1;
	logic                         trk_ready;
	logic                         rpt_valid, rpt_ready;
	ps2mt_pkg::report_t           rpt;
	ps2mt_pkg::report_t           out_rpt;
	logic [ps2mt_pkg::SIZE_W-1:0] pix_x, pix_y;

	// configuration registers: always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= '0;
			height_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ps2mt_pkg::REG_WIDTH_PX:  width_q  <= cfg_data;
				ps2mt_pkg::REG_HEIGHT_PX: height_q <= cfg_data;
			endcase
		end
	end

	// input register: refill as soon as the tracker takes the held beat
	assign s_tready = !v_s1 || trk_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (s_tready)
			v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1 <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	ps2mt_track u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (v_s1),
		.in_ready   (trk_ready),
		.in_mode    (mode_s1),
		.in_byte    (byte_s1),
		.width_px   (width_q),
		.height_px  (height_q),
		.out_valid  (rpt_valid),
		.out_ready  (rpt_ready),
		.out_report (rpt)
	);

	ps2mt_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (rpt_valid),
		.in_ready   (rpt_ready),
		.in_report  (rpt),
		.width_px   (width_q),
		.height_px  (height_q),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_report (out_rpt),
		.pixel_x    (pix_x),
		.pixel_y    (pix_y)
	);

	// pack the report, first field in the lowest bits
	assign m_tdata = {{(ps2mt_pkg::M_TDATA_W-PAYLOAD_W){1'b0}},
		pix_y, pix_x, out_rpt.pos_y, out_rpt.pos_x, out_rpt.buttons,
		out_rpt.move_y, out_rpt.move_x};
	assign m_tuser = out_rpt.scaled;

endmodule
`default_nettype wire

// ===== rtl/ps2mt_track.sv =====
// Packet assembly, saturating move totals and absolute position tracking.
`default_nettype none
module ps2mt_track (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire                                   in_mode,
	input  wire  [ps2mt_pkg::DATA_W-1:0]          in_byte,
	input  wire  [ps2mt_pkg::SIZE_W-1:0]          width_px,
	input  wire  [ps2mt_pkg::SIZE_W-1:0]          height_px,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output ps2mt_pkg::report_t                    out_report
);

	localparam int SW    = ps2mt_pkg::SUM_WIDTH;
	localparam int MW    = ps2mt_pkg::MOVE_W;
	localparam int PW    = ps2mt_pkg::POS_W;
	localparam int EXT_W = PW + 3;
	localparam int BW    = ps2mt_pkg::BTN_W;

	localparam logic [1:0] SLOT_HEADER = 2'd0;
	localparam logic [1:0] SLOT_X      = 2'd1;
	localparam logic [1:0] SLOT_Y      = 2'd2;

	localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};
	localparam logic signed [MW-1:0] MOVE_MAX = {1'b0, {(MW-1){1'b1}}};
	localparam logic signed [MW-1:0] MOVE_MIN = {1'b1, {(MW-1){1'b0}}};

	logic [1:0]             slot_q;
	logic [BW+1:0]          hdr_q;     // {y sign, x sign, buttons}
	logic [7:0]             xbyte_q;
	logic signed [SW-1:0]   sum_x_q, sum_y_q;
	logic [BW-1:0]          btn_q;
	logic                   seen_q;
	logic [PW-1:0]          abs_x_q, abs_y_q;
	logic                   v_s2;
	ps2mt_pkg::report_t     rpt_s2;

	logic                   produce, slot_ready, fire;
	logic [8:0]             dx9, dy9;
	logic signed [SW:0]     add_x, add_y;
	logic signed [SW-1:0]   sat_x, sat_y;
	logic signed [MW-1:0]   mv_x, mv_y;
	logic signed [EXT_W-1:0] ext_x, ext_y, step_x, step_y;
	logic [PW-1:0]          nxt_x, nxt_y;

	assign produce    = (in_mode == ps2mt_pkg::MODE_POLL_END) && seen_q;
	assign slot_ready = !v_s2 || out_ready;
	assign in_ready   = !produce || slot_ready;
	assign fire       = in_valid && in_ready;

	always_comb begin
		dx9   = {hdr_q[ps2mt_pkg::XSIGN_BIT-1], xbyte_q};
		dy9   = {hdr_q[ps2mt_pkg::YSIGN_BIT-1], in_byte};
		add_x = {sum_x_q[SW-1], sum_x_q} + $signed({{(SW-8){dx9[8]}}, dx9});
		add_y = {sum_y_q[SW-1], sum_y_q} + $signed({{(SW-8){dy9[8]}}, dy9});
		// saturate on overflow of the totals
		if (add_x[SW] != add_x[SW-1])
			sat_x = add_x[SW] ? SUM_MIN : SUM_MAX;
		else
			sat_x = add_x[SW-1:0];
		if (add_y[SW] != add_y[SW-1])
			sat_y = add_y[SW] ? SUM_MIN : SUM_MAX;
		else
			sat_y = add_y[SW-1:0];

		// clamp totals to the 8-bit signed range
		if (sum_x_q[SW-1:MW-1] == {(SW-MW+1){sum_x_q[SW-1]}})
			mv_x = sum_x_q[MW-1:0];
		else
			mv_x = sum_x_q[SW-1] ? MOVE_MIN : MOVE_MAX;
		if (sum_y_q[SW-1:MW-1] == {(SW-MW+1){sum_y_q[SW-1]}})
			mv_y = sum_y_q[MW-1:0];
		else
			mv_y = sum_y_q[SW-1] ? MOVE_MIN : MOVE_MAX;

		step_x = $signed({{(EXT_W-MW-ps2mt_pkg::STEP_SHIFT){mv_x[MW-1]}}, mv_x,
			{ps2mt_pkg::STEP_SHIFT{1'b0}}});
		step_y = $signed({{(EXT_W-MW-ps2mt_pkg::STEP_SHIFT){mv_y[MW-1]}}, mv_y,
			{ps2mt_pkg::STEP_SHIFT{1'b0}}});
		ext_x  = $signed({3'b000, abs_x_q}) + step_x;
		ext_y  = $signed({3'b000, abs_y_q}) - step_y;

		if (ext_x[EXT_W-1])
			nxt_x = '0;
		else if (ext_x[EXT_W-2:PW] != '0)
			nxt_x = ps2mt_pkg::POS_MAX;
		else
			nxt_x = ext_x[PW-1:0];
		if (ext_y[EXT_W-1])
			nxt_y = '0;
		else if (ext_y[EXT_W-2:PW] != '0)
			nxt_y = ps2mt_pkg::POS_MAX;
		else
			nxt_y = ext_y[PW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= SLOT_HEADER;
			hdr_q   <= '0;
			xbyte_q <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			btn_q   <= '0;
			seen_q  <= 1'b0;
			abs_x_q <= ps2mt_pkg::POS_CENTER;
			abs_y_q <= ps2mt_pkg::POS_CENTER;
		end else if (fire) begin
			if (in_mode == ps2mt_pkg::MODE_BYTE) begin
				unique case (slot_q)
					SLOT_X: begin
						xbyte_q <= in_byte;
						slot_q  <= SLOT_Y;
					end
					SLOT_Y: begin
						sum_x_q <= sat_x;
						sum_y_q <= sat_y;
						btn_q   <= hdr_q[BW-1:0];
						seen_q  <= 1'b1;
						slot_q  <= SLOT_HEADER;
					end
					default: begin
						// out of sync: drop bytes without the sync bit
						if (in_byte[ps2mt_pkg::SYNC_BIT]) begin
							hdr_q  <= {in_byte[ps2mt_pkg::YSIGN_BIT],
								in_byte[ps2mt_pkg::XSIGN_BIT], in_byte[BW-1:0]};
							slot_q <= SLOT_X;
						end else begin
							slot_q <= SLOT_HEADER;
						end
					end
				endcase
			end else if (seen_q) begin
				abs_x_q <= nxt_x;
				abs_y_q <= nxt_y;
				sum_x_q <= '0;
				sum_y_q <= '0;
				btn_q   <= '0;
				seen_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (fire && produce)
			v_s2 <= 1'b1;
		else if (out_ready)
			v_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire && produce) begin
			rpt_s2.move_x  <= mv_x;
			rpt_s2.move_y  <= mv_y;
			rpt_s2.buttons <= btn_q;
			rpt_s2.pos_x   <= nxt_x;
			rpt_s2.pos_y   <= nxt_y;
			rpt_s2.scaled  <= (width_px != '0) && (height_px != '0);
		end
	end

	assign out_valid  = v_s2;
	assign out_report = rpt_s2;

endmodule
`default_nettype wire

// ===== rtl/ps2mt_scale.sv =====
// Pixel scaling: product register, then divide by 32767 into the output register.
`default_nettype none
module ps2mt_scale (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  ps2mt_pkg::report_t                    in_report,
	input  wire  [ps2mt_pkg::SIZE_W-1:0]          width_px,
	input  wire  [ps2mt_pkg::SIZE_W-1:0]          height_px,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output ps2mt_pkg::report_t                    out_report,
	output logic [ps2mt_pkg::SIZE_W-1:0]          pixel_x,
	output logic [ps2mt_pkg::SIZE_W-1:0]          pixel_y
);

	localparam int PR = ps2mt_pkg::PROD_W;
	localparam int PW = ps2mt_pkg::POS_W;
	localparam int SZ = ps2mt_pkg::SIZE_W;

	logic               v_s3, v_q;
	ps2mt_pkg::report_t rpt_s3, rpt_q;
	logic [PR-1:0]      prod_x_s3, prod_y_s3;
	logic [SZ-1:0]      pix_x_q, pix_y_q;
	logic               out_free, load_s3, load_out;
	logic [SZ-1:0]      div_x, div_y;

	// floor(p / 32767): q = p >> 15 leaves p - q*32767 = p[14:0] + q,
	// which stays below twice the divisor, so one correction step suffices
	function automatic logic [SZ-1:0] div_pos_max(input logic [PR-1:0] p);
		logic [PR-PW-1:0] q;
		logic [PW:0]      rem;
		q   = p[PR-1:PW];
		rem = {1'b0, p[PW-1:0]} + (PW+1)'(q);
		if (rem >= {1'b0, ps2mt_pkg::POS_MAX})
			div_pos_max = SZ'(q) + SZ'(1);
		else
			div_pos_max = SZ'(q);
	endfunction

	assign out_free = !v_q || out_ready;
	assign in_ready = !v_s3 || out_free;
	assign load_s3  = in_valid && in_ready;
	assign load_out = v_s3 && out_free;
	assign div_x    = div_pos_max(prod_x_s3);
	assign div_y    = div_pos_max(prod_y_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (load_s3)
				v_s3 <= 1'b1;
			else if (load_out)
				v_s3 <= 1'b0;
			if (load_out)
				v_q <= 1'b1;
			else if (out_ready)
				v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s3) begin
			rpt_s3    <= in_report;
			prod_x_s3 <= PR'(in_report.pos_x) * PR'(width_px);
			prod_y_s3 <= PR'(in_report.pos_y) * PR'(height_px);
		end
		if (load_out) begin
			rpt_q   <= rpt_s3;
			pix_x_q <= rpt_s3.scaled ? div_x : '0;
			pix_y_q <= rpt_s3.scaled ? div_y : '0;
		end
	end

	assign out_valid  = v_q;
	assign out_report = rpt_q;
	assign pixel_x    = pix_x_q;
	assign pixel_y    = pix_y_q;

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the PS/2 mouse packet tracker: directed table, then random polls.
`timescale 1ns / 1ps

module tb_top;

	localparam int DATA_W     = ps2mt_pkg::DATA_W;
	localparam int MOVE_W     = ps2mt_pkg::MOVE_W;
	localparam int BTN_W      = ps2mt_pkg::BTN_W;
	localparam int POS_W      = ps2mt_pkg::POS_W;
	localparam int SIZE_W     = ps2mt_pkg::SIZE_W;
	localparam int SUM_WIDTH  = ps2mt_pkg::SUM_WIDTH;
	localparam int STEP_SHIFT = ps2mt_pkg::STEP_SHIFT;
	localparam int M_TDATA_W  = ps2mt_pkg::M_TDATA_W;
	localparam int CFG_IDX_W  = ps2mt_pkg::CFG_IDX_W;
	localparam int SYNC_BIT   = ps2mt_pkg::SYNC_BIT;
	localparam int XSIGN_BIT  = ps2mt_pkg::XSIGN_BIT;
	localparam int YSIGN_BIT  = ps2mt_pkg::YSIGN_BIT;
	localparam logic [POS_W-1:0] POS_MAX    = ps2mt_pkg::POS_MAX;
	localparam logic [POS_W-1:0] POS_CENTER = ps2mt_pkg::POS_CENTER;
	localparam logic MODE_BYTE     = ps2mt_pkg::MODE_BYTE;
	localparam logic MODE_POLL_END = ps2mt_pkg::MODE_POLL_END;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_PX  = ps2mt_pkg::REG_WIDTH_PX;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_PX = ps2mt_pkg::REG_HEIGHT_PX;

	localparam int HALF_PERIOD  = 5;
	localparam int RESET_CYCLES = 8;
	// Leave margin for the report pipeline and its output stage to go quiet.
	localparam int SETTLE_CYCLES = 10;
	localparam longint RUN_LIMIT_NS = 5_000_000;
	localparam longint POS_STEP = longint'(1) <<< STEP_SHIFT;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 32;

	// Screen sizes per phase; the last phases draw random sizes.
	localparam int SCREEN_W_SET [0:5] = '{8192, 1, 16383, 0, 8192, 640};
	localparam int SCREEN_H_SET [0:5] = '{8192, 1, 16383, 8192, 0, 480};

	// Report fields, highest first, so that {m_tuser, m_tdata[76:0]} maps straight onto it.
	typedef struct packed {
		logic                     scaled;
		logic [SIZE_W-1:0]        pix_y;
		logic [SIZE_W-1:0]        pix_x;
		logic [POS_W-1:0]         pos_y;
		logic [POS_W-1:0]         pos_x;
		logic [BTN_W-1:0]         buttons;
		logic signed [MOVE_W-1:0] move_y;
		logic signed [MOVE_W-1:0] move_x;
	} rep_fields_t;

	localparam int REPORT_BITS = $bits(rep_fields_t) - 1;

	typedef struct packed {
		logic        mode;
		logic [7:0]  data;
		logic        pinned;   // expected report typed in below instead of predicted
		rep_fields_t rep;
	} stim_row_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_THIRD, RX_HOLD} rx_style_t;

	// Directed stimulus: sync loss, zero packet, both move extremes, a packet split across
	// polls, overflow bits set in a header, and idle polls. Screen sizes are still zero.
	localparam stim_row_t DIRECTED [0:24] = '{
		'{MODE_POLL_END, 8'h00, 1'b0, '0},   // idle poll right after reset
		'{MODE_BYTE,     8'h00, 1'b0, '0},   // no sync bit: dropped
		'{MODE_BYTE,     8'hF7, 1'b0, '0},   // every bit but sync: dropped
		'{MODE_BYTE,     8'h08, 1'b0, '0},
		'{MODE_BYTE,     8'h00, 1'b0, '0},
		'{MODE_BYTE,     8'h00, 1'b0, '0},
		'{MODE_POLL_END, 8'h00, 1'b1, '{move_x: 8'h00, move_y: 8'h00, buttons: 3'd0,
			pos_x: 15'd16384, pos_y: 15'd16384, scaled: 1'b0, pix_x: '0, pix_y: '0}},
		'{MODE_BYTE,     8'h3F, 1'b0, '0},   // both signs, all buttons
		'{MODE_BYTE,     8'h00, 1'b0, '0},   // -256
		'{MODE_BYTE,     8'h00, 1'b0, '0},   // -256
		'{MODE_POLL_END, 8'hFF, 1'b1, '{move_x: 8'h80, move_y: 8'h80, buttons: 3'd7,
			pos_x: 15'd0, pos_y: 15'd32767, scaled: 1'b0, pix_x: '0, pix_y: '0}},
		'{MODE_BYTE,     8'h0F, 1'b0, '0},
		'{MODE_BYTE,     8'hFF, 1'b0, '0},   // +255
		'{MODE_BYTE,     8'hFF, 1'b0, '0},   // +255
		'{MODE_POLL_END, 8'h00, 1'b1, '{move_x: 8'h7F, move_y: 8'h7F, buttons: 3'd7,
			pos_x: 15'd32767, pos_y: 15'd0, scaled: 1'b0, pix_x: '0, pix_y: '0}},
		'{MODE_BYTE,     8'h09, 1'b0, '0},
		'{MODE_BYTE,     8'h05, 1'b0, '0},
		'{MODE_POLL_END, 8'h00, 1'b0, '0},   // packet still open: nothing to report
		'{MODE_BYTE,     8'h03, 1'b0, '0},   // completes the held packet
		'{MODE_POLL_END, 8'h00, 1'b0, '0},
		'{MODE_BYTE,     8'hF8, 1'b0, '0},   // overflow bits high, both signs
		'{MODE_BYTE,     8'h80, 1'b0, '0},
		'{MODE_BYTE,     8'h7F, 1'b0, '0},
		'{MODE_POLL_END, 8'h00, 1'b0, '0},
		'{MODE_POLL_END, 8'hA5, 1'b0, '0}    // idle poll again
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [DATA_W-1:0]     s_tdata;    // [7:0] data_byte
	logic                  s_tuser;    // [0] mode
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// [7:0] move_x, [15:8] move_y, [18:16] button_bits, [33:19] position_x,
	// [48:34] position_y, [62:49] pixel_x, [76:63] pixel_y, [79:77] zero
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  m_tuser;    // [0] scaled_valid
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [SIZE_W-1:0]     cfg_data;

	// Tracker model state, mirrored from the block's reset values.
	logic [1:0]                  trk_slot;
	logic [7:0]                  trk_hdr;
	logic [7:0]                  trk_xbyte;
	logic signed [SUM_WIDTH-1:0] trk_sum_x;
	logic signed [SUM_WIDTH-1:0] trk_sum_y;
	logic [BTN_W-1:0]            trk_btn;
	logic                        trk_seen;
	logic [POS_W-1:0]            trk_pos_x;
	logic [POS_W-1:0]            trk_pos_y;
	logic [SIZE_W-1:0]           scr_w;
	logic [SIZE_W-1:0]           scr_h;

	rep_fields_t pending_reports [$];
	int          fail_cnt = 0;
	int          live_items = 0;     // beats that changed tracker state
	int          burst_left = 0;
	int          rx_left = 0;
	rx_style_t   rx_style = RX_OPEN;

	ps2_mouse_packet_tracker u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Saturating add into a SUM_WIDTH-bit signed poll total.
	function automatic logic signed [SUM_WIDTH-1:0] sat_sum(
			input logic signed [SUM_WIDTH-1:0] acc, input longint delta);
		longint hi;
		hi = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
		return SUM_WIDTH'(clip(longint'(acc) + delta, -hi - 1, hi));
	endfunction

	// Advance the tracker by one beat. Returns 1 when the beat yields a report;
	// live drops to 0 for beats the block ignores (unsynced bytes, idle polls).
	function automatic bit track_beat(input logic mode, input logic [7:0] b,
			output rep_fields_t rep, output bit live);
		longint dx;
		longint dy;
		rep = '0;
		live = 1'b1;
		if (mode == MODE_BYTE) begin
			if (trk_slot == 2'd1) begin
				trk_xbyte = b;
				trk_slot = 2'd2;
			end else if (trk_slot == 2'd2) begin
				trk_btn = trk_hdr[BTN_W-1:0];
				trk_sum_x = sat_sum(trk_sum_x, longint'($signed({trk_hdr[XSIGN_BIT], trk_xbyte})));
				trk_sum_y = sat_sum(trk_sum_y, longint'($signed({trk_hdr[YSIGN_BIT], b})));
				trk_seen = 1'b1;
				trk_slot = 2'd0;
			end else begin
				// slot 0 (and the unreachable slot 3): hunt for a header
				trk_slot = 2'd0;
				if (b[SYNC_BIT]) begin
					trk_hdr = b;
					trk_slot = 2'd1;
				end else begin
					live = 1'b0;
				end
			end
			return 1'b0;
		end
		if (!trk_seen) begin
			live = 1'b0;
			return 1'b0;
		end
		dx = clip(longint'(trk_sum_x), -128, 127);
		dy = clip(longint'(trk_sum_y), -128, 127);
		// Y is inverted: a positive device move goes up the screen.
		trk_pos_x = POS_W'(clip(longint'(trk_pos_x) + dx * POS_STEP, 0, longint'(POS_MAX)));
		trk_pos_y = POS_W'(clip(longint'(trk_pos_y) - dy * POS_STEP, 0, longint'(POS_MAX)));
		rep.move_x  = MOVE_W'(dx);
		rep.move_y  = MOVE_W'(dy);
		rep.buttons = trk_btn;
		rep.pos_x   = trk_pos_x;
		rep.pos_y   = trk_pos_y;
		rep.scaled  = (scr_w != '0) && (scr_h != '0);
		if (rep.scaled) begin
			rep.pix_x = SIZE_W'(longint'(trk_pos_x) * longint'(scr_w) / longint'(POS_MAX));
			rep.pix_y = SIZE_W'(longint'(trk_pos_y) * longint'(scr_h) / longint'(POS_MAX));
		end
		trk_sum_x = '0;
		trk_sum_y = '0;
		trk_btn = '0;
		trk_seen = 1'b0;
		return 1'b1;
	endfunction

	// Move byte biased toward the extremes of the 9-bit range.
	function automatic logic [7:0] move_byte();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			3: return 8'h7F;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Send one beat in the current burst; open a new burst after a random gap when
	// the old one runs out. Predict at acceptance and queue any report.
	task automatic send_beat(input logic mode, input logic [7:0] b,
			input logic pinned = 1'b0, input rep_fields_t fixed = '0);
		rep_fields_t rep;
		bit          live;
		bit          has_rep;
		int          gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			// Mostly short bursts, now and then a long unbroken stretch.
			burst_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(40, 120))
				: int'($urandom_range(1, 8));
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		has_rep = track_beat(mode, b, rep, live);
		if (live)
			live_items++;
		if (has_rep)
			pending_reports.push_back(pinned ? fixed : rep);
	endtask

	// Hold the input until every report is out and the pipeline has gone quiet.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both screen sizes back to back; valid stays high across the two beats.
	task automatic set_screen(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
		cfg_valid <= 1'b1;
		cfg_index <= REG_WIDTH_PX;
		cfg_data  <= w;
		do @(posedge clk); while (!cfg_ready);
		scr_w = w;
		cfg_index <= REG_HEIGHT_PX;
		cfg_data  <= h;
		do @(posedge clk); while (!cfg_ready);
		scr_h = h;
		cfg_valid <= 1'b0;
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_cnt++;
		end
	endtask

	// Receiver: pick a stall style for a random stretch, then move to the next.
	always @(posedge clk) begin : rx_pattern
		if (rx_left == 0) begin
			rx_style = rx_style_t'($urandom_range(0, 3));
			rx_left = $urandom_range(8, 60);
		end
		rx_left--;
		case (rx_style)
			RX_OPEN:  m_tready <= 1'b1;
			RX_COIN:  m_tready <= 1'($urandom_range(0, 1));
			RX_THIRD: m_tready <= (rx_left % 3 == 0);
			default:  m_tready <= 1'b0;   // hold off for the whole stretch
		endcase
	end

	// Compare each report beat with the oldest prediction.
	always @(posedge clk) begin : report_check
		rep_fields_t seen;
		rep_fields_t want;
		if (arst_n && m_tvalid && m_tready) begin
			seen = rep_fields_t'({m_tuser, m_tdata[REPORT_BITS-1:0]});
			if (pending_reports.size() == 0) begin
				$error("report beat with none pending: %h", seen);
				fail_cnt++;
			end else begin
				want = pending_reports.pop_front();
				check_field("move_x", longint'(want.move_x), longint'(seen.move_x));
				check_field("move_y", longint'(want.move_y), longint'(seen.move_y));
				check_field("button_bits", longint'(want.buttons), longint'(seen.buttons));
				check_field("position_x", longint'(want.pos_x), longint'(seen.pos_x));
				check_field("position_y", longint'(want.pos_y), longint'(seen.pos_y));
				check_field("scaled_valid", longint'(want.scaled), longint'(seen.scaled));
				check_field("pixel_x", longint'(want.pix_x), longint'(seen.pix_x));
				check_field("pixel_y", longint'(want.pix_y), longint'(seen.pix_y));
			end
		end
	end

	initial begin : run_limit
		#(RUN_LIMIT_NS);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin : stimulus
		int  pick;
		int  goal;
		int  npk;
		logic [7:0] hdr;

		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = MODE_BYTE;
		cfg_valid = 1'b0;
		cfg_index = REG_WIDTH_PX;
		cfg_data  = '0;
		trk_slot  = '0;
		trk_hdr   = '0;
		trk_xbyte = '0;
		trk_sum_x = '0;
		trk_sum_y = '0;
		trk_btn   = '0;
		trk_seen  = 1'b0;
		trk_pos_x = POS_CENTER;
		trk_pos_y = POS_CENTER;
		scr_w     = '0;
		scr_h     = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(DIRECTED); i++)
			send_beat(DIRECTED[i].mode, DIRECTED[i].data, DIRECTED[i].pinned, DIRECTED[i].rep);

		for (int ph = 0; ph < PHASES; ph++) begin
			// Sizes change only with the block idle; this also drains it fully.
			settle();
			if (ph < $size(SCREEN_W_SET))
				set_screen(SIZE_W'(SCREEN_W_SET[ph]), SIZE_W'(SCREEN_H_SET[ph]));
			else
				set_screen(SIZE_W'($urandom_range(1, 8192)), SIZE_W'($urandom_range(1, 8192)));

			if (ph == 0) begin
				// One long poll: push X past the positive total limit and Y past the
				// negative one, then swing both back, so saturation shows in the clamp.
				repeat (130) begin
					send_beat(MODE_BYTE, 8'h28);
					send_beat(MODE_BYTE, 8'hFF);
					send_beat(MODE_BYTE, 8'h00);
				end
				repeat (129) begin
					send_beat(MODE_BYTE, 8'h18);
					send_beat(MODE_BYTE, 8'h00);
					send_beat(MODE_BYTE, 8'hFF);
				end
				send_beat(MODE_POLL_END, 8'h00);
			end

			goal = live_items + PHASE_ITEMS;
			while (live_items < goal) begin
				pick = $urandom_range(0, 99);
				hdr = 8'($urandom_range(0, 255)) | (8'h01 << SYNC_BIT);
				if (pick < 8) begin
					// noise byte, may or may not carry the sync bit
					send_beat(MODE_BYTE, 8'($urandom_range(0, 255)));
				end else if (pick < 14) begin
					// packet cut short by a poll end
					send_beat(MODE_BYTE, hdr);
					if ($urandom_range(0, 1) == 1)
						send_beat(MODE_BYTE, move_byte());
					send_beat(MODE_POLL_END, 8'($urandom_range(0, 255)));
				end else if (pick < 20) begin
					send_beat(MODE_POLL_END, 8'($urandom_range(0, 255)));
				end else begin
					npk = $urandom_range(1, 3);
					repeat (npk) begin
						send_beat(MODE_BYTE, hdr);
						send_beat(MODE_BYTE, move_byte());
						send_beat(MODE_BYTE, move_byte());
						hdr = 8'($urandom_range(0, 255)) | (8'h01 << SYNC_BIT);
					end
					send_beat(MODE_POLL_END, 8'($urandom_range(0, 255)));
				end
			end
		end

		settle();
		if (fail_cnt == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
